### rtl/twal_pkg.sv
// Shared types and constants for the timed attribute write log.
// Used by twal_ctrl, timed_attribute_write_log and the testbench; no dependencies.
package twal_pkg;

  localparam int ATTR_BYTES = 1024;
  localparam int LOG_DEPTH  = 1024;

  localparam int ATTR_AW = (ATTR_BYTES > 1) ? $clog2(ATTR_BYTES) : 1;
  localparam int LOG_AW  = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int COUNT_W = $clog2(LOG_DEPTH + 1);

  typedef enum logic [2:0] {
    ACT_BEGIN  = 3'd0,
    ACT_BASE   = 3'd1,
    ACT_RECORD = 3'd2,
    ACT_REWIND = 3'd3,
    ACT_APPLY  = 3'd4,
    ACT_FLUSH  = 3'd5,
    ACT_CLEAR  = 3'd6,
    ACT_READ   = 3'd7
  } action_t;

  typedef struct packed {
    action_t     action;
    logic        zero_baseline;
    logic [9:0]  scan_line;
    logic [15:0] byte_offset;
    logic [7:0]  byte_value;
  } in_word_t;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  read_data;
    logic        log_overflowed;
    logic [10:0] entries_logged;
  } out_word_t;

  typedef struct packed {
    logic [9:0]         line;
    logic [ATTR_AW-1:0] offset;
    logic [7:0]         value;
  } log_entry_t;

  localparam int LOG_W = $bits(log_entry_t);

  // Port of an attribute store RAM
  typedef struct packed {
    logic               we;
    logic [ATTR_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic               re;
    logic [ATTR_AW-1:0] raddr;
  } attr_port_t;

  // Port of the change log RAM
  typedef struct packed {
    logic              we;
    logic [LOG_AW-1:0] waddr;
    log_entry_t        wdata;
    logic              re;
    logic [LOG_AW-1:0] raddr;
  } log_port_t;

endpackage

### rtl/twal_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module twal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/twal_ctrl.sv
// Sequencer of the timed attribute write log: address counter, replay cursor,
// log count and the result register. Depends on twal_pkg; drives three RAMs.
module twal_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  twal_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output twal_pkg::out_word_t  out_word,
  output twal_pkg::attr_port_t base_req,
  input  logic [7:0]           base_rdata,
  output twal_pkg::attr_port_t cur_req,
  input  logic [7:0]           cur_rdata,
  output twal_pkg::log_port_t  log_req,
  input  twal_pkg::log_entry_t log_rdata
);

  typedef enum logic [2:0] {
    S_SWEEP, S_IDLE, S_COPY, S_COPY_TAIL, S_RP_RD, S_RP_WR, S_RESP
  } state_t;

  localparam logic [twal_pkg::ATTR_AW-1:0] ADDR_LAST =
    twal_pkg::ATTR_AW'(twal_pkg::ATTR_BYTES - 1);
  localparam logic [twal_pkg::COUNT_W-1:0] LOG_FULL =
    twal_pkg::COUNT_W'(twal_pkg::LOG_DEPTH);

  state_t                          state_r, state_nxt;
  logic [twal_pkg::COUNT_W-1:0]    count_r, count_nxt;
  logic [twal_pkg::COUNT_W-1:0]    cursor_r, cursor_nxt;
  logic                            ovf_r, ovf_nxt;
  logic                            item_r, item_nxt;
  logic                            out_valid_r, out_valid_nxt;
  twal_pkg::out_word_t             out_word_r, out_word_nxt;
  logic [twal_pkg::ATTR_AW-1:0]    cnt_r, cnt_nxt;
  logic                            sweep_both_r, sweep_both_nxt;
  logic                            cp_vld_r, cp_vld_nxt;
  logic [twal_pkg::ATTR_AW-1:0]    cp_addr_r, cp_addr_nxt;
  logic                            match_r, match_nxt;
  logic [9:0]                      line_r, line_nxt;
  logic                            acc_r, acc_nxt;
  logic                            rd_r, rd_nxt;
  logic                            offset_ok;
  logic [twal_pkg::ATTR_AW-1:0]    offset_idx;

  assign offset_ok  = 32'(in_word.byte_offset) < twal_pkg::ATTR_BYTES;
  assign offset_idx = twal_pkg::ATTR_AW'(in_word.byte_offset);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cursor_nxt     = cursor_r;
    ovf_nxt        = ovf_r;
    item_nxt       = item_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_word_nxt   = out_word_r;
    cnt_nxt        = cnt_r;
    sweep_both_nxt = sweep_both_r;
    cp_vld_nxt     = cp_vld_r;
    cp_addr_nxt    = cp_addr_r;
    match_nxt      = match_r;
    line_nxt       = line_r;
    acc_nxt        = acc_r;
    rd_nxt         = rd_r;
    base_req       = '0;
    cur_req        = '0;
    log_req        = '0;

    unique case (state_r)
      S_SWEEP: begin
        base_req.we    = 1'b1;
        base_req.waddr = cnt_r;
        cur_req.we     = sweep_both_r;
        cur_req.waddr  = cnt_r;
        cnt_nxt        = cnt_r + twal_pkg::ATTR_AW'(1);
        if (cnt_r == ADDR_LAST) begin
          state_nxt = item_r ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = 1'b1;
          acc_nxt  = 1'b1;
          rd_nxt   = 1'b0;
          cnt_nxt  = '0;
          state_nxt = S_RESP;
          unique case (in_word.action)
            twal_pkg::ACT_BEGIN: begin
              count_nxt      = '0;
              cursor_nxt     = '0;
              ovf_nxt        = 1'b0;
              sweep_both_nxt = 1'b0;
              if (in_word.zero_baseline) begin
                state_nxt = S_SWEEP;
              end
            end
            twal_pkg::ACT_BASE: begin
              base_req.we    = offset_ok;
              base_req.waddr = offset_idx;
              base_req.wdata = in_word.byte_value;
              acc_nxt        = offset_ok;
            end
            twal_pkg::ACT_RECORD: begin
              priority if (!offset_ok) begin
                acc_nxt = 1'b0;
              end else if (count_r >= LOG_FULL) begin
                acc_nxt = 1'b0;
                ovf_nxt = 1'b1;
              end else begin
                log_req.we           = 1'b1;
                log_req.waddr        = twal_pkg::LOG_AW'(count_r);
                log_req.wdata.line   = in_word.scan_line;
                log_req.wdata.offset = offset_idx;
                log_req.wdata.value  = in_word.byte_value;
                count_nxt            = count_r + twal_pkg::COUNT_W'(1);
              end
            end
            twal_pkg::ACT_REWIND: begin
              cursor_nxt = '0;
              cp_vld_nxt = 1'b0;
              state_nxt  = S_COPY;
            end
            twal_pkg::ACT_APPLY: begin
              match_nxt = 1'b1;
              line_nxt  = in_word.scan_line;
              state_nxt = S_RP_RD;
            end
            twal_pkg::ACT_FLUSH: begin
              match_nxt = 1'b0;
              state_nxt = S_RP_RD;
            end
            twal_pkg::ACT_CLEAR: begin
              count_nxt      = '0;
              cursor_nxt     = '0;
              ovf_nxt        = 1'b0;
              sweep_both_nxt = 1'b1;
              state_nxt      = S_SWEEP;
            end
            twal_pkg::ACT_READ: begin
              cur_req.re    = offset_ok;
              cur_req.raddr = offset_idx;
              acc_nxt       = offset_ok;
              rd_nxt        = offset_ok;
            end
            default: ;
          endcase
        end
      end
      S_COPY: begin
        // read baseline at cnt, write current one entry behind
        base_req.re    = 1'b1;
        base_req.raddr = cnt_r;
        cur_req.we     = cp_vld_r;
        cur_req.waddr  = cp_addr_r;
        cur_req.wdata  = base_rdata;
        cp_vld_nxt     = 1'b1;
        cp_addr_nxt    = cnt_r;
        cnt_nxt        = cnt_r + twal_pkg::ATTR_AW'(1);
        if (cnt_r == ADDR_LAST) begin
          state_nxt = S_COPY_TAIL;
        end
      end
      S_COPY_TAIL: begin
        cur_req.we    = 1'b1;
        cur_req.waddr = cp_addr_r;
        cur_req.wdata = base_rdata;
        state_nxt     = S_RESP;
      end
      S_RP_RD: begin
        if (cursor_r < count_r) begin
          log_req.re    = 1'b1;
          log_req.raddr = twal_pkg::LOG_AW'(cursor_r);
          state_nxt     = S_RP_WR;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RP_WR: begin
        if (!match_r || (log_rdata.line == line_r)) begin
          cur_req.we    = 1'b1;
          cur_req.waddr = log_rdata.offset;
          cur_req.wdata = log_rdata.value;
          cursor_nxt    = cursor_r + twal_pkg::COUNT_W'(1);
          state_nxt     = S_RP_RD;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt               = 1'b1;
          out_word_nxt.accepted       = acc_r;
          out_word_nxt.read_data      = rd_r ? cur_rdata : 8'd0;
          out_word_nxt.log_overflowed = ovf_r;
          out_word_nxt.entries_logged = 11'(count_r);
          state_nxt                   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      count_r      <= '0;
      cursor_r     <= '0;
      ovf_r        <= 1'b0;
      item_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
      sweep_both_r <= 1'b1;
      cp_vld_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      cursor_r     <= cursor_nxt;
      ovf_r        <= ovf_nxt;
      item_r       <= item_nxt;
      out_valid_r  <= out_valid_nxt;
      cnt_r        <= cnt_nxt;
      sweep_both_r <= sweep_both_nxt;
      cp_vld_r     <= cp_vld_nxt;
    end
    out_word_r <= out_word_nxt;
    cp_addr_r  <= cp_addr_nxt;
    match_r    <= match_nxt;
    line_r     <= line_nxt;
    acc_r      <= acc_nxt;
    rd_r       <= rd_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

### rtl/timed_attribute_write_log.sv
// Timed attribute write log: a baseline store, a current store and a per-frame
// log of scanline-stamped writes, each in its own RAM, driven by one sequencer.
// Depends on twal_pkg, twal_ram and twal_ctrl.
//
// Each word in gives one word out. Baseline byte, record, read and a begin
// frame that keeps the baseline go from idle straight to the response state.
// Rewind copies the baseline store into the current store through one address
// counter. Clear sweeps both stores; begin frame with zero_baseline sweeps the
// baseline store only. Apply line and flush replay the log one entry at a time,
// reading each entry and then writing its byte into the current store; flush
// runs to the end of the log, and an apply also stops on an entry of another
// line. After reset a clearing pass zeroes both stores; in_ready stays low
// until it ends. in_ready is high only while the block is idle; a finished word
// waits in the output register.
module timed_attribute_write_log (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  twal_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output twal_pkg::out_word_t out_word
);

  twal_pkg::attr_port_t base_req;
  twal_pkg::attr_port_t cur_req;
  twal_pkg::log_port_t  log_req;
  logic [7:0]           base_rdata;
  logic [7:0]           cur_rdata;
  logic [twal_pkg::LOG_W-1:0] log_rdata_raw;
  twal_pkg::log_entry_t log_rdata;

  assign log_rdata = twal_pkg::log_entry_t'(log_rdata_raw);

  twal_ram #(.WIDTH(8), .DEPTH(twal_pkg::ATTR_BYTES)) u_base_ram (
    .clk   (clk),
    .we    (base_req.we),
    .waddr (base_req.waddr),
    .wdata (base_req.wdata),
    .re    (base_req.re),
    .raddr (base_req.raddr),
    .rdata (base_rdata)
  );

  twal_ram #(.WIDTH(8), .DEPTH(twal_pkg::ATTR_BYTES)) u_cur_ram (
    .clk   (clk),
    .we    (cur_req.we),
    .waddr (cur_req.waddr),
    .wdata (cur_req.wdata),
    .re    (cur_req.re),
    .raddr (cur_req.raddr),
    .rdata (cur_rdata)
  );

  twal_ram #(.WIDTH(twal_pkg::LOG_W), .DEPTH(twal_pkg::LOG_DEPTH)) u_log_ram (
    .clk   (clk),
    .we    (log_req.we),
    .waddr (log_req.waddr),
    .wdata (log_req.wdata),
    .re    (log_req.re),
    .raddr (log_req.raddr),
    .rdata (log_rdata_raw)
  );

  twal_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word),
    .base_req   (base_req),
    .base_rdata (base_rdata),
    .cur_req    (cur_req),
    .cur_rdata  (cur_rdata),
    .log_req    (log_req),
    .log_rdata  (log_rdata)
  );

`ifndef SYNTHESIS
  // every accepted word takes the sequencer out of idle, so in_ready falls
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after an accepted word");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_word.entries_logged) <= twal_pkg::LOG_DEPTH))
    else $error("entries_logged above log depth");

  a_read_data_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word.read_data != 8'd0)) |-> out_word.accepted)
    else $error("read data on a rejected word");

  // the log is never written and replayed in the same cycle
  a_log_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    log_req.we |-> !log_req.re)
    else $error("log RAM written during replay");
`endif

endmodule

### dv/timed_attribute_write_log_tb.sv
// Self-checking testbench for timed_attribute_write_log: random bursty words in,
// a stalling receiver out, and a scoreboard that predicts every output word.
// Depends on twal_pkg and the timed_attribute_write_log RTL.
module timed_attribute_write_log_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import twal_pkg::*;

  localparam int RANDOM_WORDS = 675;
  localparam int IDLE_LIMIT   = 20000;

  // Mirror of the stores and log; predicts one output word per input word.
  class attr_log_scoreboard;
    logic [7:0]  baseline_bytes [ATTR_BYTES];
    logic [7:0]  current_bytes  [ATTR_BYTES];
    logic [9:0]  entry_line     [LOG_DEPTH];
    logic [15:0] entry_offset   [LOG_DEPTH];
    logic [7:0]  entry_value    [LOG_DEPTH];
    int unsigned entry_count;
    int unsigned cursor;
    bit          overflow;
    out_word_t   pending[$];
    int          errors;

    function new();
      foreach (baseline_bytes[i]) baseline_bytes[i] = '0;
      foreach (current_bytes[i]) current_bytes[i] = '0;
      entry_count = 0;
      cursor      = 0;
      overflow    = 1'b0;
      errors      = 0;
    endfunction

    function void replay_entry();
      if (entry_offset[cursor] < ATTR_BYTES)
        current_bytes[entry_offset[cursor]] = entry_value[cursor];
      cursor++;
    endfunction

    function void note_word(in_word_t w);
      out_word_t res;
      logic      ok;
      logic [7:0] rd;
      ok = 1'b1;
      rd = '0;
      case (w.action)
        ACT_BEGIN: begin
          if (w.zero_baseline)
            foreach (baseline_bytes[i]) baseline_bytes[i] = '0;
          entry_count = 0;
          cursor      = 0;
          overflow    = 1'b0;
        end
        ACT_BASE: begin
          if (w.byte_offset < ATTR_BYTES) baseline_bytes[w.byte_offset] = w.byte_value;
          else ok = 1'b0;
        end
        ACT_RECORD: begin
          if (w.byte_offset >= ATTR_BYTES) begin
            ok = 1'b0;
          end else if (entry_count >= LOG_DEPTH) begin
            overflow = 1'b1;
            ok       = 1'b0;
          end else begin
            entry_line[entry_count]   = w.scan_line;
            entry_offset[entry_count] = w.byte_offset;
            entry_value[entry_count]  = w.byte_value;
            entry_count++;
          end
        end
        ACT_REWIND: begin
          foreach (current_bytes[i]) current_bytes[i] = baseline_bytes[i];
          cursor = 0;
        end
        ACT_APPLY: begin
          while (cursor < entry_count && cursor < LOG_DEPTH &&
                 entry_line[cursor] == w.scan_line)
            replay_entry();
        end
        ACT_FLUSH: begin
          while (cursor < entry_count && cursor < LOG_DEPTH)
            replay_entry();
        end
        ACT_CLEAR: begin
          foreach (baseline_bytes[i]) baseline_bytes[i] = '0;
          foreach (current_bytes[i]) current_bytes[i] = '0;
          entry_count = 0;
          cursor      = 0;
          overflow    = 1'b0;
        end
        default: begin
          if (w.byte_offset < ATTR_BYTES) rd = current_bytes[w.byte_offset];
          else ok = 1'b0;
        end
      endcase
      res.accepted       = ok;
      res.read_data      = rd;
      res.log_overflowed = overflow;
      res.entries_logged = entry_count[10:0];
      pending.push_back(res);
    endfunction

    function void report_field(string field, int unsigned want, int unsigned got);
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected output word, expected none, actual 0x%0h", $time, got);
        return;
      end
      want = pending.pop_front();
      if (got.accepted !== want.accepted)
        report_field("accepted", want.accepted, got.accepted);
      if (got.read_data !== want.read_data)
        report_field("read_data", want.read_data, got.read_data);
      if (got.log_overflowed !== want.log_overflowed)
        report_field("log_overflowed", want.log_overflowed, got.log_overflowed);
      if (got.entries_logged !== want.entries_logged)
        report_field("entries_logged", want.entries_logged, got.entries_logged);
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;

  attr_log_scoreboard sb = new();
  int words_sent  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;

  timed_attribute_write_log u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Both handshakes observed at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_word(in_word);
    if (rst_n && out_valid && out_ready) sb.check_word(out_word);
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("** timed_attribute_write_log: FAILED **");
    $finish;
  end

  // Receiver: alternates between always ready, coin-flip and long stalls.
  initial begin : receiver
    int mode;
    int hold;
    out_ready = 1'b0;
    hold      = 0;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(20, 200)) begin
        @(negedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          default: begin
            if (hold > 0) begin
              hold--;
              out_ready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
              hold = $urandom_range(1, 16);
              out_ready <= 1'b0;
            end else begin
              out_ready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  function automatic in_word_t mk(action_t act, logic zb, logic [9:0] ln,
                                  logic [15:0] off, logic [7:0] val);
    in_word_t w;
    w.action        = act;
    w.zero_baseline = zb;
    w.scan_line     = ln;
    w.byte_offset   = off;
    w.byte_value    = val;
    return w;
  endfunction

  // Half from a small hot set so reads hit written bytes; a few out of range.
  function automatic logic [15:0] pick_offset();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 16'($urandom_range(0, 31));
    if (r < 18) return 16'($urandom_range(0, ATTR_BYTES - 1));
    return 16'($urandom_range(ATTR_BYTES, 65535));
  endfunction

  function automatic in_word_t any_word();
    return mk(action_t'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
              10'($urandom_range(0, 1023)), 16'($urandom_range(0, 65535)),
              8'($urandom_range(0, 255)));
  endfunction

  task automatic send_word(input in_word_t w);
    @(negedge clk);
    in_valid = 1'b1;
    in_word  = w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  endtask

  task automatic read_back(input int n);
    repeat (n) send_word(mk(ACT_READ, 1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
                            pick_offset(), 8'($urandom_range(0, 255))));
  endtask

  task automatic directed_words();
    send_word(mk(ACT_CLEAR,  1'b0, 10'd0,    16'd0,     8'h00));
    send_word(mk(ACT_READ,   1'b0, 10'd0,    16'd0,     8'h00));
    send_word(mk(ACT_BASE,   1'b0, 10'd0,    16'd0,     8'hFF));
    send_word(mk(ACT_BASE,   1'b1, 10'd1023, 16'd1023,  8'hA5));
    send_word(mk(ACT_BASE,   1'b0, 10'd0,    16'd1024,  8'h01));
    send_word(mk(ACT_BASE,   1'b0, 10'd0,    16'hFFFF,  8'h02));
    send_word(mk(ACT_RECORD, 1'b0, 10'd0,    16'd0,     8'h5A));
    send_word(mk(ACT_RECORD, 1'b0, 10'd0,    16'd1023,  8'hFF));
    send_word(mk(ACT_RECORD, 1'b1, 10'd1023, 16'd1,     8'h00));
    send_word(mk(ACT_RECORD, 1'b0, 10'd5,    16'hFFFF,  8'h33));
    send_word(mk(ACT_REWIND, 1'b0, 10'd0,    16'd0,     8'h00));
    send_word(mk(ACT_READ,   1'b0, 10'd0,    16'd0,     8'h00));
    send_word(mk(ACT_APPLY,  1'b0, 10'd7,    16'd0,     8'h00));
    send_word(mk(ACT_APPLY,  1'b0, 10'd0,    16'd0,     8'h00));
    send_word(mk(ACT_READ,   1'b0, 10'd0,    16'd0,     8'h00));
    send_word(mk(ACT_READ,   1'b0, 10'd0,    16'd1023,  8'h00));
    send_word(mk(ACT_FLUSH,  1'b0, 10'd0,    16'd0,     8'h00));
    send_word(mk(ACT_READ,   1'b0, 10'd0,    16'd1,     8'h00));
    send_word(mk(ACT_READ,   1'b0, 10'd0,    16'hFFFF,  8'h00));
    send_word(mk(ACT_BEGIN,  1'b0, 10'd0,    16'd0,     8'h00));
    send_word(mk(ACT_REWIND, 1'b0, 10'd0,    16'd0,     8'h00));
    send_word(mk(ACT_READ,   1'b0, 10'd0,    16'd1023,  8'h00));
    send_word(mk(ACT_BEGIN,  1'b1, 10'd0,    16'd0,     8'h00));
    send_word(mk(ACT_REWIND, 1'b0, 10'd0,    16'd0,     8'h00));
    send_word(mk(ACT_READ,   1'b0, 10'd0,    16'd1023,  8'h00));
  endtask

  // One frame: begin, baseline, records on rising lines, rewind, replay, read.
  task automatic random_frame();
    logic [9:0] ln;
    logic [9:0] lines[$];
    int         r;
    send_word(mk(ACT_BEGIN, 1'($urandom_range(0, 3) == 0), 10'($urandom_range(0, 1023)),
                 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255))));
    repeat ($urandom_range(0, 6))
      send_word(mk(ACT_BASE, 1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
                   pick_offset(), 8'($urandom_range(0, 255))));
    ln = 10'($urandom_range(0, 1023));
    lines.push_back(ln);
    repeat ($urandom_range(1, 20)) begin
      if ($urandom_range(0, 2) == 0) begin
        ln = ln + 10'($urandom_range(1, 2));
        lines.push_back(ln);
      end
      send_word(mk(ACT_RECORD, 1'($urandom_range(0, 1)), ln, pick_offset(),
                   8'($urandom_range(0, 255))));
    end
    read_back($urandom_range(0, 2));
    send_word(mk(ACT_REWIND, 1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
                 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255))));
    foreach (lines[i]) begin
      r = $urandom_range(0, 9);
      if (r == 1)
        send_word(mk(ACT_APPLY, 1'b0, 10'($urandom_range(0, 1023)), 16'd0, 8'h00));
      if (r == 2) begin
        send_word(mk(ACT_FLUSH, 1'b0, 10'($urandom_range(0, 1023)), 16'd0, 8'h00));
        break;
      end
      if (r != 0)
        send_word(mk(ACT_APPLY, 1'($urandom_range(0, 1)), lines[i],
                     16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255))));
    end
    if ($urandom_range(0, 1) == 0)
      send_word(mk(ACT_FLUSH, 1'b0, 10'($urandom_range(0, 1023)), 16'd0, 8'h00));
    read_back($urandom_range(1, 4));
    if ($urandom_range(0, 9) < 2)
      repeat ($urandom_range(1, 3)) send_word(any_word());
    if ($urandom_range(0, 29) == 0)
      send_word(mk(ACT_CLEAR, 1'b0, 10'd0, 16'd0, 8'h00));
  endtask

  initial begin : stimulus
    int random_start;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_word  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed_words();
    random_start = words_sent;
    while (words_sent - random_start < RANDOM_WORDS) random_frame();

    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0)
      $display("** timed_attribute_write_log: PASSED **");
    else
      $display("** timed_attribute_write_log: FAILED **");
    $finish;
  end

endmodule

### filelist.f
rtl/twal_pkg.sv
rtl/twal_ram.sv
rtl/twal_ctrl.sv
rtl/timed_attribute_write_log.sv
dv/timed_attribute_write_log_tb.sv
